// ----- hw/rtl/arcr_pkg.sv -----
// ----------------------------------------------------------------------------
// arcr_pkg
// Shared types and codes for the address range cache router.
// ----------------------------------------------------------------------------
`default_nettype none

package arcr_pkg;

   // command codes
   localparam logic CMD_ROUTE  = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // bound select codes
   localparam logic BOUND_START = 1'b0;
   localparam logic BOUND_END   = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;

   // configuration register indexes (byte address / 4)
   localparam logic [1:0] REG_BYPASS_ALL   = 2'd0;
   localparam logic [1:0] REG_HIT_LATENCY  = 2'd1;
   localparam logic [1:0] REG_RULES_IN_USE = 2'd2;

   localparam int CSR_ADDR_BITS = 4;

   // control part of a word moving down the cell chain
   typedef struct packed {
      logic       valid;
      logic       command;
      logic       eligible;
      logic [2:0] rule_index;
      logic       bound_select;
      logic       hit;
      logic [1:0] status;
   } arcr_word_type;

endpackage : arcr_pkg

`default_nettype wire

// ----- hw/rtl/arcr_if.sv -----
// ----------------------------------------------------------------------------
// arcr_req_if / arcr_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface arcr_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] address;
   logic        is_read_op;
   logic [2:0]  rule_index;
   logic        bound_select;
   logic [31:0] bound_value;

   modport source (
      output valid, command, address, is_read_op, rule_index, bound_select,
             bound_value,
      input  ready
   );
   modport sink (
      input  valid, command, address, is_read_op, rule_index, bound_select,
             bound_value,
      output ready
   );
endinterface : arcr_req_if

interface arcr_rsp_if;
   logic       valid;
   logic       ready;
   logic       to_cache;
   logic [7:0] added_latency;
   logic [1:0] status;

   modport source (
      output valid, to_cache, added_latency, status,
      input  ready
   );
   modport sink (
      input  valid, to_cache, added_latency, status,
      output ready
   );
endinterface : arcr_rsp_if

`default_nettype wire

// ----- hw/rtl/arcr_cell.sv -----
// ----------------------------------------------------------------------------
// arcr_cell
// One rule of the range table: matches passing route words against its
// range and applies update words that address it.
// ----------------------------------------------------------------------------
`default_nettype none

module arcr_cell #(
   parameter int CELL_INDEX = 0,
   parameter int KEY_BITS   = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          advance,
   input  wire  [3:0]                   rules_in_use,
   input  wire  arcr_pkg::arcr_word_type word_in,
   input  wire  [KEY_BITS-1:0]          key_in,
   output arcr_pkg::arcr_word_type      word_out,
   output logic [KEY_BITS-1:0]          key_out
);
   import arcr_pkg::*;

   logic [KEY_BITS-1:0] start_ff, start_in;
   logic [KEY_BITS-1:0] end_ff, end_in;
   arcr_word_type       word_ff, word_in_nx;
   logic [KEY_BITS-1:0] key_ff;

   logic cell_active;
   logic addressed;
   logic in_range;
   logic [KEY_BITS-1:0] new_start, new_end;

   assign cell_active = int'(rules_in_use) > CELL_INDEX;
   assign addressed   = int'(word_in.rule_index) == CELL_INDEX;
   assign in_range    = (key_in >= start_ff) && (key_in < end_ff);

   always_comb begin
      new_start  = start_ff;
      new_end    = end_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      word_in_nx = word_in;
      if (word_in.bound_select == BOUND_START) begin
         new_start = key_in;
      end else begin
         new_end = key_in;
      end
      if (word_in.valid) begin
         if (word_in.command == CMD_ROUTE) begin
            if (word_in.eligible && cell_active && in_range) begin
               word_in_nx.hit = 1'b1;
            end
         end else if (addressed && word_in.status == STATUS_OK) begin
            // refuse an empty range, keep the table unchanged
            if (new_start >= new_end) begin
               word_in_nx.status = STATUS_EMPTY;
            end else begin
               start_in = new_start;
               end_in   = new_end;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         word_ff  <= '0;
         key_ff   <= '0;
      end else if (advance) begin
         start_ff <= start_in;
         end_ff   <= end_in;
         word_ff  <= word_in_nx;
         key_ff   <= key_in;
      end
   end

   assign word_out = word_ff;
   assign key_out  = key_ff;

endmodule : arcr_cell

`default_nettype wire

// ----- hw/rtl/address_range_cache_router_core.sv -----
// ----------------------------------------------------------------------------
// address_range_cache_router_core
// Routes requests to the cache or bypass output by a table of address ranges.
// ----------------------------------------------------------------------------
// Each word enters a chain of NUM_RULES cells, one cell per rule, and moves
// one cell per cycle while the chain advances; a route word collects range
// hits as it passes and an update word rewrites the one bound of the cell it
// addresses. One word is accepted every cycle while no result is held; the
// first cell register loads at the edge that takes the word and the output
// register follows the last cell. When a result is held at the output the
// whole chain stalls and req_chan.ready drops. Configuration registers are
// bypass_all (0x0), hit_latency (0x4) and rules_in_use (0x8).
`default_nettype none

module address_range_cache_router_core #(
   parameter int NUM_RULES = 8,
   parameter int ADDR_BITS = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   arcr_req_if.sink                            req_chan,
   arcr_rsp_if.source                          rsp_chan,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [arcr_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire  [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import arcr_pkg::*;

   localparam int KEY_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;

   // configuration
   logic       bypass_all_ff;
   logic [7:0] hit_latency_ff;
   logic [3:0] rules_in_use_ff;
   logic       csr_write;
   logic [1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_all_ff   <= 1'b0;
         hit_latency_ff  <= '0;
         rules_in_use_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BYPASS_ALL:   bypass_all_ff   <= csr_pwdata[0];
            REG_HIT_LATENCY:  hit_latency_ff  <= csr_pwdata[7:0];
            REG_RULES_IN_USE: rules_in_use_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_BYPASS_ALL:   csr_prdata = {31'd0, bypass_all_ff};
         REG_HIT_LATENCY:  csr_prdata = {24'd0, hit_latency_ff};
         REG_RULES_IN_USE: csr_prdata = {28'd0, rules_in_use_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // chain entry
   arcr_word_type       word_chain [NUM_RULES+1];
   logic [KEY_BITS-1:0] key_chain  [NUM_RULES+1];
   arcr_word_type       entry_word;
   logic [KEY_BITS-1:0] entry_key;
   logic                advance;
   logic                bad_index;
   logic                out_valid_ff;
   logic                to_cache_ff;
   logic [7:0]          latency_ff;
   logic [1:0]          status_ff;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   assign bad_index = (int'(req_chan.rule_index) >= int'(rules_in_use_ff)) ||
                      (int'(req_chan.rule_index) >= NUM_RULES);

   always_comb begin
      entry_word.valid        = req_chan.valid;
      entry_word.command      = req_chan.command;
      entry_word.eligible     = (req_chan.command == CMD_ROUTE) &&
                                req_chan.is_read_op && !bypass_all_ff;
      entry_word.rule_index   = req_chan.rule_index;
      entry_word.bound_select = req_chan.bound_select;
      entry_word.hit          = 1'b0;
      entry_word.status       = ((req_chan.command == CMD_UPDATE) && bad_index) ?
                                STATUS_BAD_INDEX : STATUS_OK;
      entry_key = (req_chan.command == CMD_ROUTE) ?
                  req_chan.address[KEY_BITS-1:0] :
                  req_chan.bound_value[KEY_BITS-1:0];
   end

   assign word_chain[0] = entry_word;
   assign key_chain[0]  = entry_key;

   for (genvar g = 0; g < NUM_RULES; g++) begin : g_cell
      arcr_cell #(
         .CELL_INDEX (g),
         .KEY_BITS   (KEY_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .rules_in_use (rules_in_use_ff),
         .word_in      (word_chain[g]),
         .key_in       (key_chain[g]),
         .word_out     (word_chain[g+1]),
         .key_out      (key_chain[g+1])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= word_chain[NUM_RULES].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         to_cache_ff <= word_chain[NUM_RULES].hit;
         latency_ff  <= word_chain[NUM_RULES].hit ? hit_latency_ff : 8'd0;
         status_ff   <= word_chain[NUM_RULES].status;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.to_cache      = to_cache_ff;
   assign rsp_chan.added_latency = latency_ff;
   assign rsp_chan.status        = status_ff;

`ifndef SYNTHESIS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while result is held");

   a_bypass_no_latency: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.to_cache) |-> (rsp_chan.added_latency == 8'd0))
      else $error("latency on a bypass result");

   a_refused_not_cached: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != STATUS_OK) |-> !rsp_chan.to_cache)
      else $error("refused update routed to cache");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.status == STATUS_OK ||
                          rsp_chan.status == STATUS_BAD_INDEX ||
                          rsp_chan.status == STATUS_EMPTY))
      else $error("undefined status code");
`endif

endmodule : address_range_cache_router_core

`default_nettype wire
